// ===== design/ips_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ips_pkg: shared types, constants and helpers
// Holds the CORDIC constants, the sideband type that travels with the rotation
// pipeline, register indexes and the fixed point truncation and saturation helpers.
// ----------------------------------------------------------------------------
package ips_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int XY_W = 34;
  localparam int Z_W = 33;
  localparam int W_W = 36;
  localparam int T_W = 24;

  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [31:0] ATAN_TURN32 [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_PWM_PERIOD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_T_SQRT3 = 2'd1;
  localparam logic [15:0] PWM_PERIOD_RESET = 16'd4000;
  localparam logic [15:0] T_SQRT3_RESET = 16'd13856;

  typedef struct packed {
    logic signed [15:0] v_q;
    logic signed [15:0] v_d;
    logic [1:0]         quad;
  } side_t;

  typedef struct packed {
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
  } ab_t;

  typedef struct packed {
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
    logic [15:0]        duty_a;
    logic [15:0]        duty_b;
    logic [15:0]        duty_c;
  } res_t;

  typedef enum logic [2:0] {
    FORM_YZ = 3'b001,
    FORM_XZ = 3'b010,
    FORM_YX = 3'b100
  } form_t;

  // Signed division by 2**s that truncates toward zero.
  function automatic logic signed [36:0] tdiv(input logic signed [36:0] v,
                                               input int unsigned s);
    logic signed [36:0] bias;
    bias = v[36] ? ((37'sd1 <<< s) - 37'sd1) : 37'sd0;
    return (v + bias) >>> s;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [36:0] v);
    logic signed [15:0] r;
    if (v < -37'sd32768) begin
      r = 16'sh8000;
    end else if (v > 37'sd32767) begin
      r = 16'sh7fff;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic [15:0] usat16(input logic signed [T_W-1:0] v);
    logic [15:0] r;
    if (v < 24'sd0) begin
      r = 16'h0000;
    end else if (v > 24'sd65535) begin
      r = 16'hffff;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ===== design/ips_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ips_cordic: pipelined rotation CORDIC
// One iteration per register stage. Starts from the gain compensated unit
// vector and rotates it by the residual angle, carrying sideband data along.
// ----------------------------------------------------------------------------
module ips_cordic
  import ips_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic signed [Z_W-1:0]  in_z,
  input  side_t                  in_side,
  output logic                   out_valid,
  output logic signed [XY_W-1:0] out_x,
  output logic signed [XY_W-1:0] out_y,
  output side_t                  out_side
);

  logic                   v    [CORDIC_STEPS+1];
  logic signed [XY_W-1:0] x    [CORDIC_STEPS+1];
  logic signed [XY_W-1:0] y    [CORDIC_STEPS+1];
  logic signed [Z_W-1:0]  z    [CORDIC_STEPS+1];
  side_t                  side [CORDIC_STEPS+1];

  assign v[0] = in_valid;
  assign x[0] = CORDIC_GAIN;
  assign y[0] = '0;
  assign z[0] = in_z;
  assign side[0] = in_side;

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!z[k][Z_W-1]) begin
          x[k+1] <= x[k] - (y[k] >>> k);
          y[k+1] <= y[k] + (x[k] >>> k);
          z[k+1] <= z[k] - $signed({1'b0, ATAN_TURN32[k]});
        end else begin
          x[k+1] <= x[k] + (y[k] >>> k);
          y[k+1] <= y[k] - (x[k] >>> k);
          z[k+1] <= z[k] + $signed({1'b0, ATAN_TURN32[k]});
        end
        side[k+1] <= side[k];
      end
    end
  end

  assign out_valid = v[CORDIC_STEPS];
  assign out_x = x[CORDIC_STEPS];
  assign out_y = y[CORDIC_STEPS];
  assign out_side = side[CORDIC_STEPS];

endmodule

// ===== design/inverse_park_svpwm_duty.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inverse_park_svpwm_duty: inverse Park transform and space vector duties
// Takes an angle and the q and d voltage commands, returns alpha, beta and
// three phase compare values.
// ----------------------------------------------------------------------------
// The block accepts one request every cycle while the skid register is empty
// and returns its result through the input register, the 24 stage CORDIC that
// forms sine and cosine, the multiply and sector stages and the output register.
// A result that is not taken moves into a one-entry skid register, so a single
// output stall does not stop the input at once. Configuration writes are always
// taken and must only happen while no request is in flight.
// ----------------------------------------------------------------------------
module inverse_park_svpwm_duty
  import ips_pkg::*;
#(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [15:0]     angle,
  input  logic signed [15:0]     v_q,
  input  logic signed [15:0]     v_d,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [15:0]     v_alpha,
  output logic signed [15:0]     v_beta,
  output logic [15:0]            duty_a,
  output logic [15:0]            duty_b,
  output logic [15:0]            duty_c,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]            cfg_data
);

  logic [15:0] pwm_period;
  logic [15:0] t_sqrt3;

  logic en;

  logic [31:0] phase;
  logic [31:0] phase_sum;
  logic [1:0]  quad_c;
  logic [31:0] rbits;

  logic                  s0_valid;
  logic signed [Z_W-1:0] s0_z;
  side_t                 s0_side;

  logic                   co_valid;
  logic signed [XY_W-1:0] co_x;
  logic signed [XY_W-1:0] co_y;
  side_t                  co_side;

  logic signed [XY_W-1:0] c_round;
  logic signed [XY_W-1:0] s_round;
  logic signed [16:0]     c17;
  logic signed [16:0]     s17;
  logic signed [16:0]     cs_c;
  logic signed [16:0]     sn_c;

  logic               r_valid;
  logic signed [16:0] r_cs;
  logic signed [16:0] r_sn;
  side_t              r_side;

  logic               p_valid;
  logic signed [32:0] p_dsn;
  logic signed [32:0] p_qcs;
  logic signed [32:0] p_qsn;
  logic signed [32:0] p_dcs;

  logic signed [36:0] sum_a;
  logic signed [36:0] sum_b;

  logic ab_valid;
  ab_t  ab;

  logic               m_valid;
  ab_t                m_ab;
  logic signed [32:0] m_ua;
  logic signed [32:0] m_bp;

  logic signed [W_W-1:0] wx_c;
  logic signed [36:0]    sum_y;
  logic signed [36:0]    sum_z;
  logic signed [36:0]    div_y;
  logic signed [36:0]    div_z;

  logic                  w_valid;
  ab_t                   w_ab;
  logic signed [W_W-1:0] wx;
  logic signed [W_W-1:0] wy;
  logic signed [W_W-1:0] wz;

  form_t              form_c;
  logic signed [36:0] diff_c;
  logic signed [36:0] dq_c;
  logic signed [36:0] qx_c;
  logic signed [36:0] qy_c;
  logic signed [36:0] qz_c;

  logic                  d1_valid;
  ab_t                   d1_ab;
  form_t                 d1_form;
  logic signed [T_W-1:0] d1_dq;
  logic signed [T_W-1:0] d1_qx;
  logic signed [T_W-1:0] d1_qy;
  logic signed [T_W-1:0] d1_qz;

  logic                  d2_valid;
  ab_t                   d2_ab;
  form_t                 d2_form;
  logic signed [T_W-1:0] d2_ta;
  logic signed [T_W-1:0] d2_qx;
  logic signed [T_W-1:0] d2_qy;
  logic signed [T_W-1:0] d2_qz;

  logic signed [T_W-1:0] tb_c;
  logic signed [T_W-1:0] tc_c;

  logic d3_valid;
  res_t d3_res;

  logic skid_valid;
  res_t skid_res;
  logic out_valid_r;
  res_t out_res;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_period <= PWM_PERIOD_RESET;
      t_sqrt3 <= T_SQRT3_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PWM_PERIOD: pwm_period <= cfg_data;
        REG_T_SQRT3:    t_sqrt3 <= cfg_data;
        default: ;
      endcase
    end
  end

  // The whole pipeline advances together unless the skid register is full.
  assign en = !skid_valid;
  assign in_ready = en;

  assign phase = {angle[15:16-SINE_TABLE_BITS], {(32-SINE_TABLE_BITS){1'b0}}};
  assign phase_sum = phase + 32'h2000_0000;
  assign quad_c = phase_sum[31:30];
  assign rbits = phase - {quad_c, 30'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_z <= $signed({rbits[31], rbits});
      s0_side <= '{v_q: v_q, v_d: v_d, quad: quad_c};
    end
  end

  ips_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s0_valid),
    .in_z      (s0_z),
    .in_side   (s0_side),
    .out_valid (co_valid),
    .out_x     (co_x),
    .out_y     (co_y),
    .out_side  (co_side)
  );

  // Round to Q1.15 and rotate into the quadrant.
  always_comb begin
    c_round = (co_x + 34'sd16384) >>> 15;
    s_round = (co_y + 34'sd16384) >>> 15;
    c17 = 17'(sat16(37'(c_round)));
    s17 = 17'(sat16(37'(s_round)));
    case (co_side.quad)
      2'd0: begin
        cs_c = c17;
        sn_c = s17;
      end
      2'd1: begin
        cs_c = -s17;
        sn_c = c17;
      end
      2'd2: begin
        cs_c = -c17;
        sn_c = -s17;
      end
      default: begin
        cs_c = s17;
        sn_c = -c17;
      end
    endcase
  end

  // Inverse Park: products, then sums with truncating scale and saturation.
  always_comb begin
    sum_a = 37'(p_dsn) + 37'(p_qcs);
    sum_b = 37'(p_qsn) - 37'(p_dcs);
  end

  // Sector split terms.
  always_comb begin
    wx_c = -(W_W'(m_bp) <<< 1);
    sum_y = 37'(wx_c) + 37'(m_ua);
    sum_z = 37'(wx_c) - 37'(m_ua);
    div_y = tdiv(sum_y, 1);
    div_z = tdiv(sum_z, 1);
  end

  always_comb begin
    if (wy[W_W-1] == wz[W_W-1]) begin
      form_c = FORM_YZ;
    end else if (wy[W_W-1]) begin
      form_c = (wx <= $signed(W_W'(0))) ? FORM_XZ : FORM_YX;
    end else begin
      form_c = (wx <= $signed(W_W'(0))) ? FORM_YX : FORM_XZ;
    end
    unique case (form_c)
      FORM_YZ: diff_c = 37'(wy) - 37'(wz);
      FORM_XZ: diff_c = 37'(wx) - 37'(wz);
      FORM_YX: diff_c = 37'(wy) - 37'(wx);
      default: diff_c = '0;
    endcase
    dq_c = tdiv(diff_c, 18);
    qx_c = tdiv(37'(wx), 17);
    qy_c = tdiv(37'(wy), 17);
    qz_c = tdiv(37'(wz), 17);
  end

  always_comb begin
    unique case (d2_form)
      FORM_YZ: begin
        tb_c = d2_ta + d2_qz;
        tc_c = d2_ta - d2_qy;
      end
      FORM_XZ: begin
        tb_c = d2_ta + d2_qz;
        tc_c = tb_c - d2_qx;
      end
      FORM_YX: begin
        tc_c = d2_ta - d2_qy;
        tb_c = tc_c + d2_qx;
      end
      default: begin
        tb_c = '0;
        tc_c = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
      p_valid <= 1'b0;
      ab_valid <= 1'b0;
      m_valid <= 1'b0;
      w_valid <= 1'b0;
      d1_valid <= 1'b0;
      d2_valid <= 1'b0;
      d3_valid <= 1'b0;
    end else if (en) begin
      r_valid <= co_valid;
      p_valid <= r_valid;
      ab_valid <= p_valid;
      m_valid <= ab_valid;
      w_valid <= m_valid;
      d1_valid <= w_valid;
      d2_valid <= d1_valid;
      d3_valid <= d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_cs <= cs_c;
      r_sn <= sn_c;
      r_side <= co_side;

      p_dsn <= 33'($signed(r_side.v_d) * r_sn);
      p_qcs <= 33'($signed(r_side.v_q) * r_cs);
      p_qsn <= 33'($signed(r_side.v_q) * r_sn);
      p_dcs <= 33'($signed(r_side.v_d) * r_cs);

      ab.alpha <= sat16(tdiv(sum_a, 15));
      ab.beta <= sat16(tdiv(sum_b, 15));

      m_ab <= ab;
      m_ua <= 33'($signed(ab.alpha) * $signed({1'b0, t_sqrt3}));
      m_bp <= 33'($signed(ab.beta) * $signed({1'b0, pwm_period}));

      w_ab <= m_ab;
      wx <= wx_c;
      wy <= div_y[W_W-1:0];
      wz <= div_z[W_W-1:0];

      d1_ab <= w_ab;
      d1_form <= form_c;
      d1_dq <= dq_c[T_W-1:0];
      d1_qx <= qx_c[T_W-1:0];
      d1_qy <= qy_c[T_W-1:0];
      d1_qz <= qz_c[T_W-1:0];

      d2_ab <= d1_ab;
      d2_form <= d1_form;
      d2_ta <= T_W'($signed({1'b0, pwm_period[15:2]})) + d1_dq;
      d2_qx <= d1_qx;
      d2_qy <= d1_qy;
      d2_qz <= d1_qz;

      d3_res.alpha <= d2_ab.alpha;
      d3_res.beta <= d2_ab.beta;
      d3_res.duty_a <= usat16(d2_ta);
      d3_res.duty_b <= usat16(tb_c);
      d3_res.duty_c <= usat16(tc_c);
    end
  end

  // Output register with a one-entry skid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_r <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid_r && !out_ready) begin
      if (en && d3_valid) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid_r <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid_r <= d3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_r && !out_ready) begin
      if (en) begin
        skid_res <= d3_res;
      end
    end else if (skid_valid) begin
      out_res <= skid_res;
    end else begin
      out_res <= d3_res;
    end
  end

  assign out_valid = out_valid_r;
  assign v_alpha = out_res.alpha;
  assign v_beta = out_res.beta;
  assign duty_a = out_res.duty_a;
  assign duty_b = out_res.duty_b;
  assign duty_c = out_res.duty_c;

endmodule
